/* sv/ccc_pkg.sv */
// ----------------------------------------------------------------------------
// ccc_pkg: shared types and constants for the circle coverage counter
// Store depths, coordinate widths, command codes, sequencer states and the
// helpers that narrow incoming coordinates and saturate the reported counts.
// ----------------------------------------------------------------------------
`default_nettype none

package ccc_pkg;

   localparam int MAX_CIRCLES = 16;
   localparam int MAX_POINTS  = 16;
   localparam int COORD_BITS  = 16;

   // field widths of the stream items
   localparam int FIELD_W = 16;
   localparam int CMD_W   = 2;
   localparam int RES_W   = 5;
   localparam int REQ_W   = 3 * FIELD_W;
   localparam int RSP_W   = 16;

   // coordinates are taken from the low EFF_BITS bits of each field
   localparam int EFF_BITS = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
   localparam int DIFF_W   = FIELD_W + 1;
   localparam int SQ_W     = 2 * DIFF_W;
   localparam int SUM_W    = SQ_W + 1;

   localparam int CIR_IDX_W = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
   localparam int PNT_IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CIR_CNT_W = $clog2(MAX_CIRCLES + 1);
   localparam int PNT_CNT_W = $clog2(MAX_POINTS + 1);
   localparam int CNT_W     = (CIR_CNT_W > PNT_CNT_W) ? CIR_CNT_W : PNT_CNT_W;

   localparam int COUNT_MAX = (1 << RES_W) - 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_CIRCLE = 2'd0,
      CMD_LOAD_POINT  = 2'd1,
      CMD_COMPUTE     = 2'd2,
      CMD_CLEAR       = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RSQ,
      ST_SQX,
      ST_SQY,
      ST_CMP,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   // sign-extend the low EFF_BITS bits of a field
   function automatic logic signed [FIELD_W-1:0] coord_of(input logic [FIELD_W-1:0] raw);
      logic signed [EFF_BITS-1:0] low;
      low = raw[EFF_BITS-1:0];
      return FIELD_W'(low);
   endfunction

   // zero-extend the low EFF_BITS bits of a field
   function automatic logic [FIELD_W-1:0] radius_of(input logic [FIELD_W-1:0] raw);
      logic [EFF_BITS-1:0] low;
      low = raw[EFF_BITS-1:0];
      return FIELD_W'(low);
   endfunction

   function automatic logic [RES_W-1:0] sat_count(input logic [CNT_W-1:0] n);
      if (32'(n) > COUNT_MAX) begin
         return RES_W'(COUNT_MAX);
      end
      return RES_W'(n);
   endfunction

endpackage

`default_nettype wire

/* sv/circle_coverage_counter.sv */
// ----------------------------------------------------------------------------
// circle_coverage_counter: point-in-circle coverage counts
// Loads circles and points into small register stores; a compute command
// tests every circle/point pair on one shared squaring multiplier.
// ----------------------------------------------------------------------------
// Load and clear commands give no result. A compute makes one r*r pass per
// circle and, per circle/point pair, two squaring passes and a compare, then
// a sweep over the points for the outside count. One item at a time is taken.
// The result waits in an output register; loads are taken while it waits.
// Reset (synchronous) empties both stores, clears the drop flag and the output.
`default_nettype none

module circle_coverage_counter (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // req_tdata: coord_x [15:0], coord_y [31:16], circle_radius [47:32]
   input  wire logic [ccc_pkg::REQ_W-1:0]   req_tdata,
   // req_tuser: command [1:0]
   input  wire logic [ccc_pkg::CMD_W-1:0]   req_tuser,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // rsp_tdata: points_outside [4:0], circles_hit [9:5], max_points [14:10],
   //            overflow [15]
   output logic [ccc_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready
);
   import ccc_pkg::*;

   // stores
   logic signed [FIELD_W-1:0] cx_mem [MAX_CIRCLES];
   logic signed [FIELD_W-1:0] cy_mem [MAX_CIRCLES];
   logic        [FIELD_W-1:0] cr_mem [MAX_CIRCLES];
   logic signed [FIELD_W-1:0] px_mem [MAX_POINTS];
   logic signed [FIELD_W-1:0] py_mem [MAX_POINTS];

   logic [CIR_CNT_W-1:0] circle_total_ff, circle_total_in;
   logic [PNT_CNT_W-1:0] point_total_ff, point_total_in;
   logic                 dropped_ff, dropped_in;

   state_type state_ff, state_in;

   logic [CIR_CNT_W-1:0]  ci_ff, ci_in;
   logic [PNT_CNT_W-1:0]  pi_ff, pi_in;
   logic [MAX_POINTS-1:0] covered_ff, covered_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]      hit_ff, hit_in;
   logic [CNT_W-1:0]      best_ff, best_in;
   logic [CNT_W-1:0]      outside_ff, outside_in;
   logic [SQ_W-1:0]       prod_ff, prod_in;
   logic [SQ_W-1:0]       d2_ff, d2_in;
   logic [SQ_W-1:0]       rsq_ff, rsq_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   logic                   req_fire;
   cmd_type                cmd;
   logic [FIELD_W-1:0]     in_x, in_y, in_r;
   logic [CIR_IDX_W-1:0]   cidx;
   logic [PNT_IDX_W-1:0]   pidx;
   logic signed [DIFF_W-1:0]   mul_op;
   logic signed [2*DIFF_W-1:0] mul_full;
   logic [SUM_W-1:0]       d2_sum;
   logic                   is_inside;
   logic                   last_point, last_circle;
   logic [CNT_W-1:0]       n_final;
   logic                   out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign in_x       = req_tdata[FIELD_W-1:0];
   assign in_y       = req_tdata[2*FIELD_W-1:FIELD_W];
   assign in_r       = req_tdata[3*FIELD_W-1:2*FIELD_W];

   assign cidx = ci_ff[CIR_IDX_W-1:0];
   assign pidx = pi_ff[PNT_IDX_W-1:0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // shared squaring unit: dx, dy or the radius, by state
   always_comb begin
      case (state_ff)
         ST_RSQ:  mul_op = $signed({1'b0, cr_mem[cidx]});
         ST_SQX:  mul_op = DIFF_W'(px_mem[pidx]) - DIFF_W'(cx_mem[cidx]);
         ST_SQY:  mul_op = DIFF_W'(py_mem[pidx]) - DIFF_W'(cy_mem[cidx]);
         default: mul_op = '0;
      endcase
      mul_full = mul_op * mul_op;
   end

   assign d2_sum      = SUM_W'(d2_ff) + SUM_W'(prod_ff);
   assign is_inside   = d2_sum <= SUM_W'(rsq_ff);
   assign last_point  = (PNT_CNT_W'(pi_ff + 1'b1) == point_total_ff);
   assign last_circle = (CIR_CNT_W'(ci_ff + 1'b1) == circle_total_ff);
   assign n_final     = n_ff + CNT_W'(is_inside);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && cmd == CMD_COMPUTE) begin
               if (circle_total_ff == '0 || point_total_ff == '0) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_RSQ;
               end
            end
         end
         ST_RSQ:  state_in = ST_SQX;
         ST_SQX:  state_in = ST_SQY;
         ST_SQY:  state_in = ST_CMP;
         ST_CMP: begin
            if (!last_point) begin
               state_in = ST_SQX;
            end else if (last_circle) begin
               state_in = ST_SWEEP;
            end else begin
               state_in = ST_RSQ;
            end
         end
         ST_SWEEP: begin
            if (pi_ff == point_total_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and control outputs
   always_comb begin
      circle_total_in = circle_total_ff;
      point_total_in  = point_total_ff;
      dropped_in      = dropped_ff;
      ci_in           = ci_ff;
      pi_in           = pi_ff;
      covered_in      = covered_ff;
      n_in            = n_ff;
      hit_in          = hit_ff;
      best_in         = best_ff;
      outside_in      = outside_ff;
      prod_in         = prod_ff;
      d2_in           = d2_ff;
      rsq_in          = rsq_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  CMD_LOAD_CIRCLE: begin
                     if (32'(circle_total_ff) >= MAX_CIRCLES) begin
                        dropped_in = 1'b1;
                     end else begin
                        circle_total_in = circle_total_ff + 1'b1;
                     end
                  end
                  CMD_LOAD_POINT: begin
                     if (32'(point_total_ff) >= MAX_POINTS) begin
                        dropped_in = 1'b1;
                     end else begin
                        point_total_in = point_total_ff + 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     circle_total_in = '0;
                     point_total_in  = '0;
                     dropped_in      = 1'b0;
                  end
                  CMD_COMPUTE: begin
                     ci_in      = '0;
                     pi_in      = '0;
                     covered_in = '0;
                     n_in       = '0;
                     hit_in     = '0;
                     best_in    = '0;
                     outside_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_RSQ: rsq_in = SQ_W'(mul_full);
         ST_SQX: prod_in = SQ_W'(mul_full);
         ST_SQY: begin
            d2_in   = prod_ff;
            prod_in = SQ_W'(mul_full);
         end
         ST_CMP: begin
            if (is_inside) begin
               covered_in[pidx] = 1'b1;
            end
            if (last_point) begin
               // close out this circle
               if (n_final != '0) begin
                  hit_in = hit_ff + 1'b1;
               end
               if (n_final > best_ff) begin
                  best_in = n_final;
               end
               n_in  = '0;
               pi_in = '0;
               ci_in = ci_ff + 1'b1;
            end else begin
               n_in  = n_final;
               pi_in = pi_ff + 1'b1;
            end
         end
         ST_SWEEP: begin
            // count points that no circle covered
            if (pi_ff != point_total_ff) begin
               if (!covered_ff[pidx]) begin
                  outside_in = outside_ff + 1'b1;
               end
               pi_in = pi_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {dropped_ff, sat_count(best_ff), sat_count(hit_ff),
                               sat_count(outside_ff)};
            end
         end
         default: ;
      endcase
   end

   // store writes
   always_ff @(posedge clock) begin
      if (req_fire && cmd == CMD_LOAD_CIRCLE && 32'(circle_total_ff) < MAX_CIRCLES) begin
         cx_mem[circle_total_ff[CIR_IDX_W-1:0]] <= coord_of(in_x);
         cy_mem[circle_total_ff[CIR_IDX_W-1:0]] <= coord_of(in_y);
         cr_mem[circle_total_ff[CIR_IDX_W-1:0]] <= radius_of(in_r);
      end
      if (req_fire && cmd == CMD_LOAD_POINT && 32'(point_total_ff) < MAX_POINTS) begin
         px_mem[point_total_ff[PNT_IDX_W-1:0]] <= coord_of(in_x);
         py_mem[point_total_ff[PNT_IDX_W-1:0]] <= coord_of(in_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         circle_total_ff <= '0;
         point_total_ff  <= '0;
         dropped_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         circle_total_ff <= circle_total_in;
         point_total_ff  <= point_total_in;
         dropped_ff      <= dropped_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ci_ff       <= ci_in;
      pi_ff       <= pi_in;
      covered_ff  <= covered_in;
      n_ff        <= n_in;
      hit_ff      <= hit_in;
      best_ff     <= best_in;
      outside_ff  <= outside_in;
      prod_ff     <= prod_in;
      d2_ff       <= d2_in;
      rsq_ff      <= rsq_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

/* verif/tb_circle_coverage_counter.sv */
// ----------------------------------------------------------------------------
// tb_circle_coverage_counter: self-checking bench for the coverage counter
// Streams load, compute and clear commands into the block, keeps its own
// copy of the circle and point stores, and predicts the three coverage counts
// and the sticky drop flag for every compute. Both stream sides throttle at
// random, and the result side holds off once for a long stretch so that the
// block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_circle_coverage_counter;
   timeunit 1ns;
   timeprecision 1ps;

   import ccc_pkg::*;

   localparam int unsigned ITEM_TARGET = 1450;
   localparam int unsigned CALM_FIRST  = 500;    // request side: no idling here
   localparam int unsigned CALM_LAST   = 700;
   localparam int unsigned HOLD_START  = 1500;   // result side: long hold-off
   localparam int unsigned HOLD_LEN    = 5000;
   localparam int unsigned SINK_CALM   = 12000;  // result side: no stalls here
   localparam int unsigned SINK_CALM_LEN = 4000;
   localparam int unsigned DRAIN_CYCLES  = 1000;

   // one compute report, laid out as on rsp_tdata
   typedef struct packed {
      logic             overflow;
      logic [RES_W-1:0] max_points;
      logic [RES_W-1:0] circles_hit;
      logic [RES_W-1:0] points_outside;
   } coverage_result;

   class coverage_scoreboard;
      longint         circ_x [MAX_CIRCLES];
      longint         circ_y [MAX_CIRCLES];
      longint         circ_r [MAX_CIRCLES];
      longint         pnt_x [MAX_POINTS];
      longint         pnt_y [MAX_POINTS];
      int unsigned    circ_count;
      int unsigned    pnt_count;
      bit             dropped;
      coverage_result expected_q [$];
      int unsigned    errors;
      int unsigned    taken;

      function new();
         circ_count = 0;
         pnt_count  = 0;
         dropped    = 1'b0;
         errors     = 0;
         taken      = 0;
      endfunction

      function longint to_coord(logic [FIELD_W-1:0] raw);
         return longint'($signed(raw[EFF_BITS-1:0]));
      endfunction

      function bit covers(int unsigned p, int unsigned c);
         longint dx, dy;
         dx = pnt_x[p] - circ_x[c];
         dy = pnt_y[p] - circ_y[c];
         return (dx * dx + dy * dy) <= circ_r[c] * circ_r[c];
      endfunction

      function logic [RES_W-1:0] clip(int unsigned n);
         return (n > COUNT_MAX) ? RES_W'(COUNT_MAX) : RES_W'(n);
      endfunction

      function coverage_result tally();
         coverage_result res;
         int unsigned    outside_n, hit_n, best_n, n;
         bit             any;
         outside_n = 0;
         hit_n     = 0;
         best_n    = 0;
         for (int unsigned p = 0; p < pnt_count; p++) begin
            any = 1'b0;
            for (int unsigned c = 0; c < circ_count; c++) begin
               if (covers(p, c)) any = 1'b1;
            end
            if (!any) outside_n++;
         end
         for (int unsigned c = 0; c < circ_count; c++) begin
            n = 0;
            for (int unsigned p = 0; p < pnt_count; p++) begin
               if (covers(p, c)) n++;
            end
            if (n > 0) hit_n++;
            if (n > best_n) best_n = n;
         end
         res.points_outside = clip(outside_n);
         res.circles_hit    = clip(hit_n);
         res.max_points     = clip(best_n);
         res.overflow       = dropped;
         return res;
      endfunction

      // apply one accepted command to the shadow stores
      function void note_request(cmd_type cmd, logic [REQ_W-1:0] data);
         logic [FIELD_W-1:0] fx, fy, fr;
         fx = data[FIELD_W-1:0];
         fy = data[2*FIELD_W-1:FIELD_W];
         fr = data[3*FIELD_W-1:2*FIELD_W];
         taken++;
         case (cmd)
            CMD_LOAD_CIRCLE: begin
               if (circ_count >= MAX_CIRCLES) begin
                  dropped = 1'b1;
               end else begin
                  circ_x[circ_count] = to_coord(fx);
                  circ_y[circ_count] = to_coord(fy);
                  circ_r[circ_count] = longint'(fr[EFF_BITS-1:0]);
                  circ_count++;
               end
            end
            CMD_LOAD_POINT: begin
               if (pnt_count >= MAX_POINTS) begin
                  dropped = 1'b1;
               end else begin
                  pnt_x[pnt_count] = to_coord(fx);
                  pnt_y[pnt_count] = to_coord(fy);
                  pnt_count++;
               end
            end
            CMD_COMPUTE: begin
               expected_q.push_back(tally());
            end
            default: begin
               circ_count = 0;
               pnt_count  = 0;
               dropped    = 1'b0;
            end
         endcase
      endfunction

      task report_mismatch(string what, int unsigned got, int unsigned want);
         errors++;
         $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      endtask

      task check_result(logic [RSP_W-1:0] data);
         coverage_result got, want;
         got = data;
         if (expected_q.size() == 0) begin
            report_mismatch("unrequested result", data, 0);
            return;
         end
         want = expected_q.pop_front();
         if (got.points_outside != want.points_outside)
            report_mismatch("points_outside", got.points_outside, want.points_outside);
         if (got.circles_hit != want.circles_hit)
            report_mismatch("circles_hit", got.circles_hit, want.circles_hit);
         if (got.max_points != want.max_points)
            report_mismatch("max_points", got.max_points, want.max_points);
         if (got.overflow != want.overflow)
            report_mismatch("overflow", got.overflow, want.overflow);
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic [CMD_W-1:0]   req_tuser = CMD_LOAD_CIRCLE;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;

   coverage_scoreboard sb = new();
   int unsigned        sent_count = 0;
   int unsigned        sink_cycle = 0;

   circle_coverage_counter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side: random stalls, one long hold-off, one stretch wide open
   always @(posedge clock) begin
      sink_cycle <= sink_cycle + 1;
      if (sink_cycle >= HOLD_START && sink_cycle < HOLD_START + HOLD_LEN) begin
         rsp_tready <= 1'b0;
      end else if (sink_cycle >= SINK_CALM && sink_cycle < SINK_CALM + SINK_CALM_LEN) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 38);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(cmd_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   task automatic send_item(input cmd_type cmd, input logic [FIELD_W-1:0] x,
                            input logic [FIELD_W-1:0] y, input logic [FIELD_W-1:0] r);
      while (!(sent_count >= CALM_FIRST && sent_count < CALM_LAST) &&
             $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {r, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   function automatic logic [FIELD_W-1:0] near(logic [FIELD_W-1:0] base, int unsigned spread);
      return base + FIELD_W'($urandom_range(2 * spread)) - FIELD_W'(spread);
   endfunction

   // mostly small stores; now and then past full to hit the drop path
   function automatic int unsigned pick_size();
      if ($urandom_range(99) < 85) return $urandom_range(5);
      return $urandom_range(6, 18);
   endfunction

   // optional clear, then clustered loads around a random base, then a compute
   task automatic run_sequence();
      int unsigned        n_circ, n_pnt, spread;
      logic [FIELD_W-1:0] bx, by, cx, cy, cr, px, py;
      if ($urandom_range(99) < 70)
         send_item(CMD_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
      n_circ = pick_size();
      n_pnt  = pick_size();
      spread = ($urandom_range(99) < 60) ? $urandom_range(1, 60) : $urandom_range(1, 20000);
      bx = FIELD_W'($urandom);
      by = FIELD_W'($urandom);
      cx = bx;
      cy = by;
      cr = '0;
      while (n_circ + n_pnt > 0) begin
         if (n_circ > 0 && (n_pnt == 0 || $urandom_range(1) == 0)) begin
            cx = near(bx, spread);
            cy = near(by, spread);
            case ($urandom_range(3))
               0:       cr = FIELD_W'($urandom);
               1:       cr = FIELD_W'($urandom_range(spread / 2));
               default: cr = FIELD_W'($urandom_range(2 * spread));
            endcase
            send_item(CMD_LOAD_CIRCLE, cx, cy, cr);
            n_circ--;
         end else begin
            if ($urandom_range(99) < 20) begin
               // aim at the rim of the latest circle; exact unless cx + cr wraps
               px = cx + cr;
               py = cy;
            end else begin
               px = near(bx, spread);
               py = near(by, spread);
            end
            send_item(CMD_LOAD_POINT, px, py, FIELD_W'($urandom));
            n_pnt--;
         end
      end
      send_item(CMD_COMPUTE, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty stores, then a point with no circles
      send_item(CMD_COMPUTE, 16'hffff, 16'hffff, 16'hffff);
      send_item(CMD_LOAD_POINT, 16'h0000, 16'h0000, 16'hffff);
      send_item(CMD_COMPUTE, 16'h0000, 16'h0000, 16'h0000);
      // zero radius: a point on the centre still counts
      send_item(CMD_LOAD_CIRCLE, 16'h0000, 16'h0000, 16'h0000);
      send_item(CMD_COMPUTE, 16'h5555, 16'haaaa, 16'h5555);
      send_item(CMD_CLEAR, 16'haaaa, 16'h5555, 16'haaaa);
      // corner circle with the widest radius; far corner out, rim point in
      send_item(CMD_LOAD_CIRCLE, 16'h8000, 16'h8000, 16'hffff);
      send_item(CMD_LOAD_POINT, 16'h7fff, 16'h7fff, 16'h0000);
      send_item(CMD_LOAD_POINT, 16'h7fff, 16'h8000, 16'h0000);
      // 3-4-5 triangle exactly on the rim, and one step outside it
      send_item(CMD_LOAD_CIRCLE, 16'd100, 16'd100, 16'd5);
      send_item(CMD_LOAD_POINT, 16'd103, 16'd104, 16'h1234);
      send_item(CMD_LOAD_POINT, 16'd103, 16'd105, 16'h1234);
      send_item(CMD_COMPUTE, 16'h0000, 16'h0000, 16'h0000);
      send_item(CMD_LOAD_CIRCLE, 16'h7fff, 16'h7fff, 16'h0000);
      send_item(CMD_LOAD_POINT, 16'h8000, 16'h7fff, 16'h0000);
      send_item(CMD_COMPUTE, 16'hffff, 16'h0000, 16'hffff);
      send_item(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000);
      send_item(CMD_COMPUTE, 16'h0000, 16'hffff, 16'h0000);
      // circles only, no points
      send_item(CMD_LOAD_CIRCLE, 16'h0000, 16'h0000, 16'hffff);
      send_item(CMD_COMPUTE, 16'h1234, 16'h5678, 16'h9abc);

      while (sb.taken < ITEM_TARGET) begin
         if ($urandom_range(99) < 80) begin
            run_sequence();
         end else begin
            send_item(cmd_type'($urandom_range(3)), FIELD_W'($urandom),
                      FIELD_W'($urandom), FIELD_W'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("circle_coverage_counter verification clean");
      end else begin
         $display("circle_coverage_counter verification failed");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("circle_coverage_counter verification failed");
      $finish;
   end

endmodule
